// ----- hw/rtl/ookpd_pkg.sv -----
// ---------------------------------------------------------------------------
// ookpd_pkg: shared types and constants of the OOK remote pulse decoder
// Widths, frame constants and the structs passed between decoder modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ookpd_pkg;

   // field and register widths
   localparam int DURATION_WIDTH = 16;
   localparam int UNIT_WIDTH     = 10;
   localparam int DATA_BITS      = 12;
   localparam int ADDR_WIDTH     = 8;
   localparam int PROD_WIDTH     = DURATION_WIDTH + UNIT_WIDTH;

   // pulse_unit after reset, in microseconds per count
   localparam logic [UNIT_WIDTH-1:0] UNIT_RESET = UNIT_WIDTH'(50);

   // threshold is 2 * 350 us / pulse_unit
   localparam int HALF_T_US = 350;
   localparam int THRESH_US = 2 * HALF_T_US;

   // frame layout: four pulses per data bit plus two stop pulses
   localparam int FRAME_PULSES = DATA_BITS * 4 + 2;
   localparam int DATA_PULSES  = DATA_BITS * 4;
   localparam int COUNT_WIDTH  = 6;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // bits 9 and 10 of the data word must be set
   localparam logic [DATA_BITS-1:0] FIXED_BITS = DATA_BITS'(12'h600);

   // symbol pattern of the first two pulses: short then long
   localparam logic [1:0] LEAD_PATTERN = 2'b10;

   // classification of one pulse against the threshold
   typedef struct packed {
      logic long_pulse;
      logic on_threshold;
   } pulse_class_type;

   // one decoded frame
   typedef struct packed {
      logic                  valid_res;
      logic                  group;
      logic                  switch_on;
      logic [ADDR_WIDTH-1:0] home_address;
   } frame_result_type;

endpackage : ookpd_pkg

`default_nettype wire

// ----- hw/rtl/ookpd_req_if.sv -----
// ---------------------------------------------------------------------------
// ookpd_req_if: pulse input channel
// Valid/ready channel carrying one measured duration and the last flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ookpd_req_if;
   logic                                valid;
   logic                                ready;
   logic [ookpd_pkg::DURATION_WIDTH-1:0] duration;
   logic                                last;

   modport source (output valid, output duration, output last, input ready);
   modport sink   (input valid, input duration, input last, output ready);
endinterface : ookpd_req_if

`default_nettype wire

// ----- hw/rtl/ookpd_rsp_if.sv -----
// ---------------------------------------------------------------------------
// ookpd_rsp_if: frame result channel
// Valid/ready channel carrying one decoded frame report.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ookpd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            valid_res;
   logic                            group;
   logic                            switch_on;
   logic [ookpd_pkg::ADDR_WIDTH-1:0] home_address;

   modport source (output valid, output valid_res, output group, output switch_on,
                   output home_address, input ready);
   modport sink   (input valid, input valid_res, input group, input switch_on,
                   input home_address, output ready);
endinterface : ookpd_rsp_if

`default_nettype wire

// ----- hw/rtl/ook_remote_pulse_decoder_unit.sv -----
// ---------------------------------------------------------------------------
// ook_remote_pulse_decoder_unit: fixed-code OOK remote frame decoder
// Decodes the pulse durations of one received frame into a 12-bit command.
//
// Usage:
//  - req_chan takes one pulse duration per transaction; last marks the final
//    pulse of a frame. rsp_chan gives one report per frame, on its last pulse.
//  - csr_wr_en / csr_wr_data write pulse_unit (us per count); the threshold
//    is 700 / pulse_unit. Write it only while no frame is in flight.
//  - Throughput: one pulse per clock cycle unless a last pulse waits on a held
//    report, set by the single input register feeding one multiply-and-compare
//    stage. An accepted pulse is decoded from the input register into the frame
//    state; a last pulse's report goes to rsp_chan from the result register.
//  - When rsp_chan stalls, a held report blocks only the next last pulse;
//    other pulses keep flowing into the frame state.
//  - Reset: frame state and both channel stages cleared, pulse_unit = 50.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ook_remote_pulse_decoder_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ookpd_req_if.sink                                req_chan,
   ookpd_rsp_if.source                              rsp_chan,
   input  wire logic                                csr_wr_en,
   input  wire logic [ookpd_pkg::UNIT_WIDTH-1:0]    csr_wr_data
);

   logic [ookpd_pkg::UNIT_WIDTH-1:0]     unit_ff, unit_in;
   logic                                 in_valid_ff, in_valid_in;
   logic [ookpd_pkg::DURATION_WIDTH-1:0] in_dur_ff, in_dur_in;
   logic                                 in_last_ff, in_last_in;
   logic                                 out_valid_ff, out_valid_in;
   ookpd_pkg::frame_result_type          out_res_ff, out_res_in;

   ookpd_pkg::pulse_class_type           pulse_class;
   ookpd_pkg::frame_result_type          frame_res;
   logic                                 req_take;
   logic                                 advance;

   // configuration register
   assign unit_in = csr_wr_en ? csr_wr_data : unit_ff;

   // input stage moves on unless a report would overwrite a stalled one
   assign advance  = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end
   assign in_dur_in  = req_take ? req_chan.duration : in_dur_ff;
   assign in_last_in = req_take ? req_chan.last : in_last_ff;

   ookpd_classifier u_classifier (
      .duration    (in_dur_ff),
      .pulse_unit  (unit_ff),
      .pulse_class (pulse_class)
   );

   ookpd_frame_decoder u_frame_decoder (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .last        (in_last_ff),
      .pulse_class (pulse_class),
      .result      (frame_res)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end
   assign out_res_in = (advance && in_last_ff) ? frame_res : out_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff      <= ookpd_pkg::UNIT_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         unit_ff      <= unit_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_dur_ff  <= in_dur_in;
      in_last_ff <= in_last_in;
      out_res_ff <= out_res_in;
   end

   // result channel
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.valid_res    = out_res_ff.valid_res;
   assign rsp_chan.group        = out_res_ff.group;
   assign rsp_chan.switch_on    = out_res_ff.switch_on;
   assign rsp_chan.home_address = out_res_ff.home_address;

endmodule : ook_remote_pulse_decoder_unit

`default_nettype wire

// ----- hw/rtl/ookpd_classifier.sv -----
// ---------------------------------------------------------------------------
// ookpd_classifier: pulse length classifier
// Compares a duration against floor(700 / pulse_unit) without a divider:
// dur > floor(700/u) iff dur*u > 700, and dur == floor(700/u) iff
// dur*u <= 700 < dur*u + u.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ookpd_classifier (
   input  wire logic [ookpd_pkg::DURATION_WIDTH-1:0] duration,
   input  wire logic [ookpd_pkg::UNIT_WIDTH-1:0]     pulse_unit,
   output ookpd_pkg::pulse_class_type                pulse_class
);

   localparam logic [ookpd_pkg::PROD_WIDTH-1:0] THRESH_P =
      ookpd_pkg::PROD_WIDTH'(ookpd_pkg::THRESH_US);
   localparam logic [ookpd_pkg::UNIT_WIDTH:0] THRESH_U =
      (ookpd_pkg::UNIT_WIDTH + 1)'(ookpd_pkg::THRESH_US);

   logic [ookpd_pkg::PROD_WIDTH-1:0]  product;
   logic [ookpd_pkg::UNIT_WIDTH:0]    unit_ext;
   logic [ookpd_pkg::UNIT_WIDTH:0]    gap;
   logic                              above;
   logic                              next_above;

   // scaled duration in microseconds
   assign product  = ookpd_pkg::PROD_WIDTH'(duration) * ookpd_pkg::PROD_WIDTH'(pulse_unit);
   assign unit_ext = {1'b0, pulse_unit};
   assign gap      = THRESH_U - unit_ext;

   // dur*u > 700, and (dur+1)*u > 700
   assign above      = product > THRESH_P;
   assign next_above = (unit_ext > THRESH_U) ||
                       (product > ookpd_pkg::PROD_WIDTH'(gap));

   // zero unit: threshold is the largest duration, nothing is long
   always_comb begin
      if (pulse_unit == '0) begin
         pulse_class.long_pulse   = 1'b0;
         pulse_class.on_threshold = &duration;
      end else begin
         pulse_class.long_pulse   = above;
         pulse_class.on_threshold = !above && next_above;
      end
   end

endmodule : ookpd_classifier

`default_nettype wire

// ----- hw/rtl/ookpd_frame_decoder.sv -----
// ---------------------------------------------------------------------------
// ookpd_frame_decoder: per-frame symbol decoder
// Holds the frame state, decodes four-pulse symbols into data bits and
// forms the frame report on the last pulse.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ookpd_frame_decoder (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         last,
   input  wire ookpd_pkg::pulse_class_type   pulse_class,
   output ookpd_pkg::frame_result_type       result
);

   logic [ookpd_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic [2:0]                        symbol_ff, symbol_in;
   logic [ookpd_pkg::DATA_BITS-1:0]   word_ff, word_in;
   logic                              group_ff, group_in;
   logic                              bad_ff, bad_in;

   // updated frame state for the pulse in hand
   logic [ookpd_pkg::COUNT_WIDTH-1:0] count_upd;
   logic [2:0]                        symbol_upd;
   logic [ookpd_pkg::DATA_BITS-1:0]   word_upd;
   logic                              group_upd;
   logic                              bad_upd;

   // symbol decode
   always_comb begin
      symbol_upd = symbol_ff;
      word_upd   = word_ff;
      group_upd  = group_ff;
      bad_upd    = bad_ff;
      if (count_ff < ookpd_pkg::COUNT_WIDTH'(ookpd_pkg::DATA_PULSES)) begin
         if (pulse_class.on_threshold) begin
            bad_upd = 1'b1;
         end
         if (count_ff[1:0] != 2'd3) begin
            symbol_upd = symbol_ff | ({2'b00, pulse_class.long_pulse} << count_ff[1:0]);
         end else begin
            if (symbol_ff[1:0] != ookpd_pkg::LEAD_PATTERN) begin
               bad_upd = 1'b1;
            end
            case ({symbol_ff[2], pulse_class.long_pulse})
               2'b01: begin
                  word_upd = {1'b0, word_ff[ookpd_pkg::DATA_BITS-1:1]};
               end
               2'b10: begin
                  word_upd = {1'b1, word_ff[ookpd_pkg::DATA_BITS-1:1]};
               end
               2'b00: begin
                  // short zero: group command
                  word_upd  = {1'b0, word_ff[ookpd_pkg::DATA_BITS-1:1]};
                  group_upd = 1'b1;
               end
               default: begin
                  bad_upd  = 1'b1;
                  word_upd = {1'b0, word_ff[ookpd_pkg::DATA_BITS-1:1]};
               end
            endcase
            symbol_upd = '0;
         end
      end
      count_upd = (count_ff != ookpd_pkg::COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   end

   // frame report from the updated state
   always_comb begin
      result.valid_res    = !bad_upd &&
                            (count_upd == ookpd_pkg::COUNT_WIDTH'(ookpd_pkg::FRAME_PULSES)) &&
                            ((word_upd & ookpd_pkg::FIXED_BITS) == ookpd_pkg::FIXED_BITS);
      result.group        = group_upd;
      result.switch_on    = word_upd[ookpd_pkg::DATA_BITS-1];
      result.home_address = word_upd[ookpd_pkg::ADDR_WIDTH-1:0];
   end

   // next state: hold, update, or clear after the last pulse
   always_comb begin
      count_in  = count_ff;
      symbol_in = symbol_ff;
      word_in   = word_ff;
      group_in  = group_ff;
      bad_in    = bad_ff;
      if (advance) begin
         if (last) begin
            count_in  = '0;
            symbol_in = '0;
            word_in   = '0;
            group_in  = 1'b0;
            bad_in    = 1'b0;
         end else begin
            count_in  = count_upd;
            symbol_in = symbol_upd;
            word_in   = word_upd;
            group_in  = group_upd;
            bad_in    = bad_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         symbol_ff <= '0;
         word_ff   <= '0;
         group_ff  <= 1'b0;
         bad_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         symbol_ff <= symbol_in;
         word_ff   <= word_in;
         group_ff  <= group_in;
         bad_ff    <= bad_in;
      end
   end

endmodule : ookpd_frame_decoder

`default_nettype wire

// ----- bench/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the OOK remote pulse decoder
// Drives pulse trains into the decoder and predicts the frame report for each
// last pulse. Every report is compared field by field against the prediction.
// A short table of hand-checked pulses comes first, then random frames: mostly
// well-formed with random content, some broken, some plain noise. The pulse
// unit is changed between phases, once no report is pending. Both channels
// idle at random, with occasional stretches of back-to-back transactions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import ookpd_pkg::*;

   // one row of the hand-written pulse table
   typedef struct packed {
      logic [DURATION_WIDTH-1:0] duration;
      logic                      last;
      logic                      checked;
      frame_result_type          want;
   } pulse_row_type;

   localparam int                    TABLE_ROWS = 25;
   localparam logic [DURATION_WIDTH-1:0] DUR_MAX = {DURATION_WIDTH{1'b1}};
   localparam int                    UNIT_PLAN [6] = '{1, 1000, 700, 350, 7, 50};

   // default unit 50 gives a threshold of 14 counts
   localparam pulse_row_type DIRECTED_ROWS [TABLE_ROWS] = '{
      '{16'd0,     1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00}}, // shortest, alone
      '{16'd65535, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00}}, // longest, alone
      '{16'd14,    1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00}}, // on threshold
      // short zero: group flag
      '{16'd13,    1'b0, 1'b0, '0},
      '{16'd15,    1'b0, 1'b0, '0},
      '{16'd13,    1'b0, 1'b0, '0},
      '{16'd13,    1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00}},
      // one bit: lands in bit 11
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'd65535, 1'b0, 1'b0, '0},
      '{16'd65535, 1'b0, 1'b0, '0},
      '{16'd0,     1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 8'h00}},
      // zero bit
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'd65535, 1'b0, 1'b0, '0},
      '{16'd0,     1'b0, 1'b0, '0},
      '{16'd65535, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00}},
      // all long: pattern mismatch
      '{16'd100,   1'b0, 1'b0, '0},
      '{16'd100,   1'b0, 1'b0, '0},
      '{16'd100,   1'b0, 1'b0, '0},
      '{16'd100,   1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00}},
      // threshold hit inside a group
      '{16'd13,    1'b0, 1'b0, '0},
      '{16'd14,    1'b0, 1'b0, '0},
      '{16'd15,    1'b0, 1'b0, '0},
      '{16'd13,    1'b1, 1'b0, '0},
      // two pulses
      '{16'd65535, 1'b0, 1'b0, '0},
      '{16'd0,     1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00}}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [UNIT_WIDTH-1:0] csr_wr_data;

   ookpd_req_if req_bus ();
   ookpd_rsp_if rsp_bus ();

   ook_remote_pulse_decoder_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // decoder shadow state
   logic [UNIT_WIDTH-1:0]  unit_setting;
   logic [COUNT_WIDTH-1:0] pulse_cnt;
   logic [2:0]             lead_bits;
   logic [DATA_BITS-1:0]   shift_word;
   logic                   short_zero_seen;
   logic                   frame_broken;

   frame_result_type report_queue [$];
   int pulses_sent;
   int reports_seen;
   int error_count;
   int source_calm;
   int sink_calm;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   initial begin
      #(1_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

   // idle cycles before the next transaction, with runs of none at all
   function automatic int pick_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic logic [DURATION_WIDTH-1:0] pulse_limit();
      if (unit_setting == '0)
         return DUR_MAX;
      return DURATION_WIDTH'(THRESH_US / int'(unit_setting));
   endfunction

   // shadow decode of one pulse; returns 1 when it closes a frame
   function automatic logic decode_pulse(input logic [DURATION_WIDTH-1:0] dur,
                                         input logic last,
                                         output frame_result_type rpt);
      logic [DURATION_WIDTH-1:0] thr;
      logic                      long_p;
      thr = pulse_limit();
      rpt = '0;
      if (int'(pulse_cnt) < DATA_PULSES) begin
         long_p = (dur > thr);
         if (dur == thr)
            frame_broken = 1'b1;
         if (pulse_cnt[1:0] != 2'd3) begin
            lead_bits = lead_bits | (3'(long_p) << pulse_cnt[1:0]);
         end else begin
            if (lead_bits[1:0] != LEAD_PATTERN)
               frame_broken = 1'b1;
            if (!lead_bits[2] && long_p) begin
               shift_word = {1'b0, shift_word[DATA_BITS-1:1]};
            end else if (lead_bits[2] && !long_p) begin
               shift_word = {1'b1, shift_word[DATA_BITS-1:1]};
            end else if (!lead_bits[2] && !long_p) begin
               shift_word = {1'b0, shift_word[DATA_BITS-1:1]};
               short_zero_seen = 1'b1;
            end else begin
               frame_broken = 1'b1;
               shift_word = {1'b0, shift_word[DATA_BITS-1:1]};
            end
            lead_bits = '0;
         end
      end
      if (pulse_cnt != COUNT_MAX)
         pulse_cnt++;
      if (!last)
         return 1'b0;
      rpt.valid_res    = !frame_broken && (int'(pulse_cnt) == FRAME_PULSES) &&
                         ((shift_word & FIXED_BITS) == FIXED_BITS);
      rpt.group        = short_zero_seen;
      rpt.switch_on    = shift_word[DATA_BITS-1];
      rpt.home_address = shift_word[ADDR_WIDTH-1:0];
      pulse_cnt       = '0;
      lead_bits       = '0;
      shift_word      = '0;
      short_zero_seen = 1'b0;
      frame_broken    = 1'b0;
      return 1'b1;
   endfunction

   // duration generators around the current threshold
   function automatic logic [DURATION_WIDTH-1:0] short_pulse();
      logic [DURATION_WIDTH-1:0] thr;
      thr = pulse_limit();
      if (thr == '0)
         return '0;
      if ($urandom_range(0, 3) == 0)
         return thr - 1'b1;
      return DURATION_WIDTH'($urandom_range(0, int'(thr) - 1));
   endfunction

   function automatic logic [DURATION_WIDTH-1:0] long_pulse();
      logic [DURATION_WIDTH-1:0] thr;
      thr = pulse_limit();
      case ($urandom_range(0, 3))
         0: return thr + 1'b1;
         1: return DUR_MAX;
         default: return DURATION_WIDTH'($urandom_range(int'(thr) + 1, int'(DUR_MAX)));
      endcase
   endfunction

   function automatic logic [DURATION_WIDTH-1:0] odd_pulse();
      case ($urandom_range(0, 5))
         0: return pulse_limit();
         1: return '0;
         2: return DUR_MAX;
         3: return short_pulse();
         4: return long_pulse();
         default: return DURATION_WIDTH'($urandom);
      endcase
   endfunction

   // one pulse transaction; the report, if any, is predicted on acceptance
   task automatic send_pulse(input logic [DURATION_WIDTH-1:0] dur, input logic last,
                             input logic typed, input frame_result_type typed_rpt);
      int               gap;
      frame_result_type rpt;
      gap = pick_wait(source_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.duration <= dur;
      req_bus.last     <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pulses_sent++;
      if (decode_pulse(dur, last, rpt))
         report_queue.push_back(typed ? typed_rpt : rpt);
   endtask

   // hold off until every report is in, then let the pipeline settle
   task automatic drain_reports();
      req_bus.valid <= 1'b0;
      while (report_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_unit(input int value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= UNIT_WIDTH'(value);
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      unit_setting = UNIT_WIDTH'(value);
   endtask

   // kind 0: clean frame, 1: broken frame, 2: noise
   task automatic send_frame(input int kind);
      logic [DURATION_WIDTH-1:0] train [$];
      logic [DATA_BITS-1:0]      word;
      logic                      group_frame;
      int                        len;
      int                        spot;
      if (kind == 2) begin
         len = $urandom_range(1, 70);
         repeat (len) train.push_back(odd_pulse());
      end else begin
         word = DATA_BITS'($urandom);
         if ($urandom_range(0, 4) != 0)
            word[10:9] = 2'b11;
         group_frame = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < DATA_BITS; i++) begin
            train.push_back(short_pulse());
            train.push_back(long_pulse());
            if (word[i]) begin
               train.push_back(long_pulse());
               train.push_back(short_pulse());
            end else if (group_frame && $urandom_range(0, 1) == 1) begin
               train.push_back(short_pulse());
               train.push_back(short_pulse());
            end else begin
               train.push_back(short_pulse());
               train.push_back(long_pulse());
            end
         end
         // stop pulses
         train.push_back(odd_pulse());
         train.push_back(odd_pulse());
         if (kind == 1) begin
            spot = $urandom_range(0, DATA_PULSES - 1);
            case ($urandom_range(0, 3))
               0: void'(train.pop_back());
               1: train.push_back(odd_pulse());
               2: train[spot] = odd_pulse();
               default: train[spot] = pulse_limit();
            endcase
         end
      end
      foreach (train[i])
         send_pulse(train[i], (i == train.size() - 1), 1'b0, '0);
   endtask

   // stimulus
   initial begin
      int phase;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.duration <= '0;
      req_bus.last     <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      unit_setting     = UNIT_RESET;
      pulse_cnt        = '0;
      lead_bits        = '0;
      shift_word       = '0;
      short_zero_seen  = 1'b0;
      frame_broken     = 1'b0;
      pulses_sent      = 0;
      source_calm      = 0;
      phase            = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // hand-checked pulses at the reset unit
      foreach (DIRECTED_ROWS[i])
         send_pulse(DIRECTED_ROWS[i].duration, DIRECTED_ROWS[i].last,
                    DIRECTED_ROWS[i].checked, DIRECTED_ROWS[i].want);
      drain_reports();

      // random phases, each at its own pulse unit
      while (pulses_sent < 700) begin
         write_unit(phase < 6 ? UNIT_PLAN[phase] : $urandom_range(1, 1000));
         phase++;
         repeat ($urandom_range(3, 6)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: send_frame(0);
               6, 7:             send_frame(1);
               default:          send_frame(2);
            endcase
         end
         drain_reports();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0 && report_queue.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // report side: random stalls, compare each transaction with the oldest prediction
   initial begin
      int               stall;
      frame_result_type want;
      rsp_bus.ready <= 1'b0;
      reports_seen  = 0;
      error_count   = 0;
      sink_calm     = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = pick_wait(sink_calm);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         reports_seen++;
         if (report_queue.size() == 0) begin
            $error("frame report with no frame pending");
            error_count++;
         end else begin
            want = report_queue.pop_front();
            if (rsp_bus.valid_res !== want.valid_res) begin
               $error("valid_res mismatch: expected %0d, actual %0d",
                      want.valid_res, rsp_bus.valid_res);
               error_count++;
            end
            if (rsp_bus.group !== want.group) begin
               $error("group mismatch: expected %0d, actual %0d",
                      want.group, rsp_bus.group);
               error_count++;
            end
            if (rsp_bus.switch_on !== want.switch_on) begin
               $error("switch_on mismatch: expected %0d, actual %0d",
                      want.switch_on, rsp_bus.switch_on);
               error_count++;
            end
            if (rsp_bus.home_address !== want.home_address) begin
               $error("home_address mismatch: expected %0d, actual %0d",
                      want.home_address, rsp_bus.home_address);
               error_count++;
            end
         end
      end
   end

endmodule : tb_top

// ----- sim.f -----
hw/rtl/ookpd_pkg.sv
hw/rtl/ookpd_req_if.sv
hw/rtl/ookpd_rsp_if.sv
hw/rtl/ookpd_classifier.sv
hw/rtl/ookpd_frame_decoder.sv
hw/rtl/ook_remote_pulse_decoder_unit.sv
bench/tb_top.sv
